// ===== rtl/core/tmtw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer package
// Shared widths, character codes and character classes for the writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  // Screen geometry defaults
  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault    = 25;

  // Fixed field widths
  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 11;
  localparam int unsigned DataW = 16;

  localparam logic [CharW-1:0] TextColorReset = 8'h07;

  // Character codes
  localparam logic [CharW-1:0] ChSpace        = 8'h20;
  localparam logic [CharW-1:0] ChLastPrint    = 8'h7F;
  localparam logic [CharW-1:0] ChLineFeed     = 8'h0A;
  localparam logic [CharW-1:0] ChCarriageRet  = 8'h0D;
  localparam logic [CharW-1:0] ChBackspace    = 8'h08;

  typedef enum logic [1:0] {
    ChClsIgnore,
    ChClsPrint,
    ChClsNewline,
    ChClsBackspace
  } char_cls_e;

  function automatic char_cls_e classify(input logic [CharW-1:0] c);
    char_cls_e cls;
    case (c) inside
      [ChSpace:ChLastPrint]:       cls = ChClsPrint;
      ChLineFeed, ChCarriageRet:   cls = ChClsNewline;
      ChBackspace:                 cls = ChClsBackspace;
      default:                     cls = ChClsIgnore;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/core/text_mode_terminal_writer.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer
// Turns a stream of character bytes into cell writes for a text screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : char_code_i with in_valid_i / in_stall_o.
//   Output channel : cell_write_o, cell_address_o, cell_data_o and
//                    cursor_position_o with out_valid_o / out_stall_i.
//   Every accepted request gives exactly one result, in the cycle after it is accepted.
//   Throughput is one request per cycle while the receiver does not stall:
//   the cursor update is a compare, an increment and an add on the linear
//   position register, so the cursor loop needs no register beyond it.
//   The result register is freed in the same cycle it is taken, so a new
//   request is accepted while the previous result is being handed over.
//   When the receiver stalls with a result held, in_stall_o is raised and
//   the result and cursor hold until the stall is released.
//   Reset puts the cursor at row 0, column 0, loads attribute 0x07 into
//   the colour register and empties the result register. The user writes the
//   colour register through text_color_we_i while idle; not enforced here.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
  parameter int unsigned COLUMNS = tmtw_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = tmtw_pkg::RowsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // colour register
  input  logic                        text_color_we_i,
  input  logic [tmtw_pkg::CharW-1:0]  text_color_i,
  // character requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tmtw_pkg::CharW-1:0]  char_code_i,
  // cell write results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        cell_write_o,
  output logic [tmtw_pkg::AddrW-1:0]  cell_address_o,
  output logic [tmtw_pkg::DataW-1:0]  cell_data_o,
  output logic [tmtw_pkg::AddrW-1:0]  cursor_position_o
);
  import tmtw_pkg::*;

  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned RowW = $clog2(ROWS);
  localparam logic [ColW-1:0]  ColLast = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]  RowLast = RowW'(ROWS - 1);
  localparam logic [AddrW-1:0] RowStep = AddrW'(COLUMNS);

  // Cursor state; pos_q tracks row * COLUMNS + column (mod 2^AddrW)
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [CharW-1:0] color_q;

  // Result register
  logic             out_valid_q;
  logic             wr_q, wr_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [DataW-1:0] data_q, data_d;

  logic      in_acc;
  char_cls_e cls;
  logic      line_end;
  logic      last_row;
  logic [AddrW-1:0] next_line;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cls        = classify(char_code_i);
  assign line_end   = (col_q == ColLast);
  assign last_row   = (row_q == RowLast);
  // start of next row, or home on the last row
  assign next_line  = last_row ? '0 : (pos_q - AddrW'(col_q) + RowStep);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pos_d  = pos_q;
    wr_d   = 1'b0;
    addr_d = '0;
    data_d = '0;
    case (cls)
      ChClsPrint: begin
        wr_d   = 1'b1;
        addr_d = pos_q;
        data_d = {color_q, char_code_i};
        if (line_end) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + 1'b1;
          pos_d = next_line;
        end else begin
          col_d = col_q + 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end
      ChClsNewline: begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
        pos_d = next_line;
      end
      ChClsBackspace: begin
        if (col_q != '0) begin
          col_d  = col_q - 1'b1;
          pos_d  = pos_q - 1'b1;
          wr_d   = 1'b1;
          addr_d = pos_q - 1'b1;
          data_d = {color_q, ChSpace};
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      color_q     <= TextColorReset;
      out_valid_q <= 1'b0;
    end else begin
      if (text_color_we_i) begin
        color_q <= text_color_i;
      end
      if (in_acc) begin
        col_q       <= col_d;
        row_q       <= row_d;
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_q   <= wr_d;
      addr_q <= addr_d;
      data_q <= data_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_write_o      = wr_q;
  assign cell_address_o    = addr_q;
  assign cell_data_o       = data_q;
  assign cursor_position_o = pos_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pos_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == AddrW'(int'(row_q) * int'(COLUMNS) + int'(col_q)))
    else $error("linear cursor position out of step with row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < int'(COLUMNS)) && (int'(row_q) < int'(ROWS)))
    else $error("cursor outside the screen");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cell_write_o) |-> (cell_address_o == '0 && cell_data_o == '0))
    else $error("non-write result carries address or data");

  a_bs_col0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && char_code_i == ChBackspace && col_q == '0)
      |=> (pos_q == $past(pos_q) && !cell_write_o))
    else $error("backspace at column 0 moved the cursor or wrote a cell");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer testbench
// Feeds character requests through the writer under random idling on both
// channels and checks every cell write and cursor position it reports
// against an in-bench model of the cursor and the colour register.
// ----------------------------------------------------------------------------
module tb;
  import tmtw_pkg::*;

  localparam int unsigned Columns       = ColumnsDefault;
  localparam int unsigned Rows          = RowsDefault;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseRequests = 265;
  localparam int unsigned ColourPhases  = 6;

  // One result as the writer hands it over
  typedef struct packed {
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [AddrW-1:0] cursor;
  } cell_result_t;

  // Cursor and colour model plus the queue of results still owed
  class screen_board;
    logic [6:0]       column;
    logic [4:0]       row;
    logic [CharW-1:0] colour;
    cell_result_t     owed_cells[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      writes;
    int unsigned      row_wraps;

    function new();
      column     = '0;
      row        = '0;
      colour     = TextColorReset;
      mismatches = 0;
      checked    = 0;
      writes     = 0;
      row_wraps  = 0;
    endfunction

    // Linear index, cut to the address width as the hardware does
    function logic [AddrW-1:0] linear(logic [4:0] r, logic [6:0] c);
      int unsigned idx;
      idx = r * Columns + c;
      return idx[AddrW-1:0];
    endfunction

    function void next_line();
      if (row == Rows - 1) begin
        row = '0;
        row_wraps++;
      end else begin
        row++;
      end
    endfunction

    function void take_char(logic [CharW-1:0] c);
      cell_result_t res;
      res = '0;
      if (c >= ChSpace && c <= ChLastPrint) begin
        res.wr   = 1'b1;
        res.addr = linear(row, column);
        res.data = {colour, c};
        if (column == Columns - 1) begin
          column = '0;
          next_line();
        end else begin
          column++;
        end
      end else if (c == ChLineFeed || c == ChCarriageRet) begin
        next_line();
        column = '0;
      end else if (c == ChBackspace && column != 0) begin
        // rub out the previous cell; never steps back over a line start
        column--;
        res.wr   = 1'b1;
        res.addr = linear(row, column);
        res.data = {colour, ChSpace};
      end
      res.cursor = linear(row, column);
      owed_cells.push_back(res);
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      mismatches++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void match_cell(cell_result_t got);
      cell_result_t want;
      checked++;
      if (owed_cells.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding");
        return;
      end
      want = owed_cells.pop_front();
      if (got.wr) writes++;
      if (got.wr != want.wr) flag("cell_write", 32'(want.wr), 32'(got.wr));
      if (got.addr != want.addr) flag("cell_address", 32'(want.addr), 32'(got.addr));
      if (got.data != want.data) flag("cell_data", 32'(want.data), 32'(got.data));
      if (got.cursor != want.cursor)
        flag("cursor_position", 32'(want.cursor), 32'(got.cursor));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             text_color_we_i;
  logic [CharW-1:0] text_color_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CharW-1:0] char_code_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             cell_write_o;
  logic [AddrW-1:0] cell_address_o;
  logic [DataW-1:0] cell_data_o;
  logic [AddrW-1:0] cursor_position_o;

  screen_board board;
  bit          calm   = 1'b0;  // set for the stretch with no idling
  int unsigned cycles = 0;
  int unsigned sent   = 0;
  int unsigned useful = 0;      // requests that are not simply ignored

  text_mode_terminal_writer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .text_color_we_i   (text_color_we_i),
    .text_color_i      (text_color_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .char_code_i       (char_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_write_o      (cell_write_o),
    .cell_address_o    (cell_address_o),
    .cell_data_o       (cell_data_o),
    .cursor_position_o (cursor_position_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure: roughly one cycle in five, none in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 18);
  end

  // Sample both handshakes on the edge. Results are checked before the
  // request taken on the same edge is noted, as a result always trails its
  // request through the result register.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.match_cell({cell_write_o, cell_address_o, cell_data_o, cursor_position_o});
      if (in_valid_i && !in_stall_o)
        board.take_char(char_code_i);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request, with random idle cycles ahead of it, and hold it
  // until it is taken. Valid is only lowered when an idle cycle follows.
  task automatic send_char(input logic [CharW-1:0] c);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    if ((c >= ChSpace && c <= ChLastPrint) || c == ChLineFeed ||
        c == ChCarriageRet || c == ChBackspace)
      useful++;
  endtask

  // Drain: lower valid, wait until the last request is noted and every owed
  // result is in, then idle so the result register empties
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed_cells.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_colour(input logic [CharW-1:0] v);
    text_color_we_i <= 1'b1;
    text_color_i    <= v;
    @(posedge clk_i);
    text_color_we_i <= 1'b0;
    board.colour = v;
  endtask

  // A byte from the ignored classes: control codes and the upper half
  function automatic logic [CharW-1:0] pick_ignored();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 3))
      0: c = CharW'($urandom_range(8'h80, 8'hFF));
      1: c = CharW'($urandom_range(8'h00, 8'h07));
      2: c = CharW'($urandom_range(8'h0E, 8'h1F));
      default: begin
        case ($urandom_range(0, 2))
          0: c = 8'h09;
          1: c = 8'h0B;
          default: c = 8'h0C;
        endcase
      end
    endcase
    return c;
  endfunction

  // One burst of traffic. Most often runs of text, long enough to wrap lines,
  // plus newline runs that walk the cursor round the screen, backspace runs
  // that hit column 0, and raw noise.
  task automatic random_burst();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      len = $urandom_range(1, 100);
      repeat (len) begin
        if ($urandom_range(0, 11) == 0) send_char(ChBackspace);
        else send_char(CharW'($urandom_range(ChSpace, ChLastPrint)));
      end
    end else if (kind < 60) begin
      len = $urandom_range(1, 30);
      repeat (len) send_char($urandom_range(0, 1) ? ChLineFeed : ChCarriageRet);
    end else if (kind < 72) begin
      len = $urandom_range(1, 12);
      repeat (len) send_char(ChBackspace);
    end else if (kind < 90) begin
      len = $urandom_range(1, 8);
      repeat (len) send_char(CharW'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) send_char(pick_ignored());
    end
  endtask

  initial begin
    // Edges of every class, backspace both mid-line and at column 0
    static logic [CharW-1:0] opening [23] = '{
      8'h48, 8'h69, ChSpace, ChLastPrint, ChBackspace, ChBackspace,
      ChCarriageRet, ChBackspace, 8'h00, 8'hFF, 8'h80, 8'h1F, 8'h09,
      8'h0B, 8'h0C, 8'h0E, 8'h07, 8'h78, ChLineFeed, 8'h7E, 8'h21,
      ChBackspace, ChCarriageRet
    };
    static logic [CharW-1:0] fixed_colours [ColourPhases] = '{
      8'hFF, 8'h00, 8'h00, 8'h0F, 8'hF0, 8'h00
    };
    logic [CharW-1:0] colour;
    int unsigned      target;

    board = new();
    rst_ni          <= 1'b0;
    text_color_we_i <= 1'b0;
    text_color_i    <= '0;
    in_valid_i      <= 1'b0;
    char_code_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with the reset colour
    foreach (opening[i]) send_char(opening[i]);
    drain();

    for (int p = 0; p < ColourPhases; p++) begin
      colour = (p == 2 || p == 5) ? CharW'($urandom_range(0, 255)) : fixed_colours[p];
      write_colour(colour);
      calm   = (p == 3);
      target = useful + PhaseRequests;
      while (useful < target) random_burst();
      drain();
    end
    calm = 1'b0;

    $display("Summary: %0d character requests under %0d colour settings; %0d results checked,",
             sent, ColourPhases + 1, board.checked);
    $display("Summary: %0d cell writes, %0d wraps past the last row, %0d mismatches.",
             board.writes, board.row_wraps, board.mismatches);
    if (board.mismatches == 0 && board.owed_cells.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
